### src/cdt_pkg.sv
// Package for the cosine distance block: widths, status codes, sequencer states.
// No dependencies.
`default_nettype none
package cdt_pkg;
    localparam int MaxDimDefault   = 1024;
    localparam int ElemBitsDefault = 16;
    localparam int RowBits         = 16;
    localparam int DistBits        = 16;
    localparam int FracBits        = 14;
    localparam logic [16:0] OneQ14 = 17'd16384;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO     = 2'd1,
        ST_TOO_LONG = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQRT,
        S_MUL,
        S_DIV,
        S_FINISH,
        S_OUT
    } state_t;

    typedef enum logic {
        REG_LIMIT  = 1'b0,
        REG_FILTER = 1'b1
    } reg_index_t;
endpackage
`default_nettype wire

### src/cdt_sqrt.sv
// Iterative floor square root, one result bit per cycle.
// Depends on cdt_pkg for style only; sized by parameter W (even).
`default_nettype none
module cdt_sqrt #(
    parameter int W = 42
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [W-1:0]     value,
    output logic                  done,
    output logic [W/2-1:0]        root
);
    import cdt_pkg::*;
    localparam int H  = W / 2;
    localparam int CB = $clog2(H + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [H-1:0]  root_reg, root_next;
    logic [W-1:0]  val_reg, val_next;
    logic [CB-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W+1:0]  trial;
    logic [W+1:0]  shifted;

    always_comb
    begin
        shifted   = {rem_reg, val_reg[W-1 -: 2]};
        trial     = shifted - {{(W+2-H-2){1'b0}}, root_reg, 2'b01};
        rem_next  = rem_reg;
        root_next = root_reg;
        val_next  = val_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = busy_reg && (cnt_reg == CB'(1));
        if (start)
        begin
            rem_next  = '0;
            root_next = '0;
            val_next  = value;
            cnt_next  = CB'(H);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = val_reg << 2;
            if (!trial[W+1])
            begin
                rem_next  = trial[W-1:0];
                root_next = {root_reg[H-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[W-1:0];
                root_next = {root_reg[H-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CB'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        val_reg  <= val_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

### src/cosine_distance_threshold.sv
// Top level of the streaming cosine distance block with threshold and filter.
// Depends on cdt_pkg and cdt_sqrt.
//
// Usage: one request on the input channel carries one element pair. The
// block accumulates the dot product and both squared norms, one request per
// cycle while in_stall is low, with no result for non-final elements. On a
// request with last_elem set the block raises in_stall and runs a sequencer:
// two square roots through one shared root unit, a product formed from two
// partial products, and a 14-step restoring division, one quotient bit per
// cycle, that is cut short when the ratio saturates. A zero norm or an
// overlong pair skips the roots, the product and the division. A result sits
// in an output register until taken; requests of the next pair are still
// taken, but its final result waits in the sequencer, with in_stall high,
// until the held result leaves. A filtered pair gives no result.
// After reset all sums are zero, distance_limit is 1.0 and filter_mode is
// off. The user writes the registers over the APB port only while the block
// is idle; the block itself does not enforce this.
`default_nettype none
module cosine_distance_threshold
    import cdt_pkg::*;
#(
    parameter int MAX_DIM   = MaxDimDefault,
    parameter int ELEM_BITS = ElemBitsDefault
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [ELEM_BITS-1:0]  left_elem,
    input  wire logic [ELEM_BITS-1:0]  right_elem,
    input  wire logic                  last_elem,
    input  wire logic [RowBits-1:0]    left_row,
    input  wire logic [RowBits-1:0]    right_row,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [DistBits-1:0]        distance,
    output logic                       within_limit,
    output logic [RowBits-1:0]         pair_left,
    output logic [RowBits-1:0]         pair_right,
    output logic [1:0]                 status
);
    localparam int CB  = $clog2(MAX_DIM + 2);
    localparam int PB  = 2 * ELEM_BITS;
    localparam int NB0 = PB - 1 + $clog2(MAX_DIM + 1);
    localparam int NB  = NB0 + (NB0 % 2);
    localparam int RB  = NB / 2;
    localparam int DB  = 2 * RB;
    localparam int QW  = DB + 2;
    localparam int HB  = (RB + 1) / 2;

    logic [15:0]              limit_reg;
    logic                     filter_reg;
    logic signed [NB:0]       dot_reg;
    logic [NB-1:0]            lnorm_reg, rnorm_reg;
    logic [CB-1:0]            cnt_reg;
    state_t                   state_reg, state_next;
    logic [RB-1:0]            lroot_reg;
    logic [DB-1:0]            den_reg;
    logic [QW-1:0]            rem_reg;
    logic [14:0]              quo_reg;
    logic [3:0]               step_reg;
    logic                     neg_reg, phase_reg;
    logic [RowBits-1:0]       lrow_reg, rrow_reg;
    logic                     sq_start, sq_done;
    logic [NB-1:0]            sq_value;
    logic [RB-1:0]            sq_root;
    logic [DistBits-1:0]      dist_reg;
    logic                     within_reg, out_valid_reg;
    status_t                  status_reg;

    logic signed [ELEM_BITS-1:0] a_s, b_s;
    logic signed [PB-1:0]     ab, aa, bb;
    logic                     take, wr, over, zero;
    logic [CB-1:0]            cnt_inc;
    logic [NB:0]              mag;
    logic [QW-1:0]            rem_sh;
    logic                     q_bit;
    logic [16:0]              dist_w;
    logic [HB-1:0]            den_lo_half;

    assign pready   = 1'b1;
    assign wr       = psel && penable && pwrite;
    assign in_stall = (state_reg != S_IDLE);
    assign take     = in_valid && !in_stall;
    assign a_s      = left_elem;
    assign b_s      = right_elem;
    assign ab       = a_s * b_s;
    assign aa       = a_s * a_s;
    assign bb       = b_s * b_s;
    assign cnt_inc  = (cnt_reg <= CB'(MAX_DIM)) ? cnt_reg + 1'b1 : cnt_reg;
    assign over     = (cnt_reg > CB'(MAX_DIM));
    assign zero     = (lnorm_reg == '0) || (rnorm_reg == '0);
    assign mag      = dot_reg[NB] ? (NB+1)'(0) - dot_reg : dot_reg;
    assign rem_sh   = {rem_reg[QW-2:0], 1'b0};
    assign q_bit    = (rem_sh >= QW'(den_reg));
    assign dist_w   = neg_reg ? OneQ14 + {2'b0, quo_reg[13:0], q_bit}
                              : OneQ14 - {2'b0, quo_reg[13:0], q_bit};
    assign den_lo_half = lroot_reg[HB-1:0];

    always_comb
    begin
        prdata = '0;
        case (paddr[2])
            REG_LIMIT:  prdata = {16'd0, limit_reg};
            REG_FILTER: prdata = {31'd0, filter_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= 16'd16384;
            filter_reg <= 1'b0;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == REG_LIMIT)
                limit_reg <= pwdata[15:0];
            else
                filter_reg <= pwdata[0];
        end
    end

    assign sq_value = (state_reg == S_FINISH) ? lnorm_reg : rnorm_reg;

    cdt_sqrt #(.W(NB)) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (sq_value),
        .done  (sq_done),
        .root  (sq_root)
    );

    always_comb
    begin
        state_next = state_reg;
        sq_start   = 1'b0;
        case (state_reg)
            S_IDLE:
                if (take && last_elem)
                    state_next = S_FINISH;
            S_FINISH:
                if (over || zero)
                    state_next = S_OUT;
                else
                begin
                    sq_start   = 1'b1;
                    state_next = S_SQRT;
                end
            S_SQRT:
                if (sq_done && phase_reg)
                    state_next = S_MUL;
                else if (sq_done)
                    sq_start = 1'b1;
            S_MUL:
                if (phase_reg)
                    state_next = S_DIV;
            S_DIV:
                if (step_reg == 4'd13 || mag >= den_reg)
                    state_next = S_OUT;
            S_OUT:
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dot_reg       <= '0;
            lnorm_reg     <= '0;
            rnorm_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
                out_valid_reg <= over || !filter_reg || (dist_reg <= limit_reg);
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (take)
            begin
                cnt_reg <= cnt_inc;
                if (cnt_inc <= CB'(MAX_DIM))
                begin
                    dot_reg   <= dot_reg + (NB+1)'(ab);
                    lnorm_reg <= lnorm_reg + NB'($unsigned(aa));
                    rnorm_reg <= rnorm_reg + NB'($unsigned(bb));
                end
            end
            case (state_reg)
                S_FINISH:
                begin
                    phase_reg <= 1'b0;
                    step_reg  <= '0;
                end
                S_SQRT:
                    if (sq_done)
                        phase_reg <= !phase_reg;
                S_MUL:
                    phase_reg <= !phase_reg;
                S_DIV:
                    step_reg <= step_reg + 1'b1;
                S_OUT:
                    if (!out_valid_reg || !out_stall)
                    begin
                        dot_reg   <= '0;
                        lnorm_reg <= '0;
                        rnorm_reg <= '0;
                        cnt_reg   <= '0;
                    end
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            lrow_reg <= left_row;
            rrow_reg <= right_row;
        end
        case (state_reg)
            S_FINISH:
            begin
                neg_reg <= dot_reg[NB];
                quo_reg <= '0;
                if (over)
                    dist_reg <= 16'd32768;
                else
                    dist_reg <= 16'd16384;
            end
            S_SQRT:
                if (sq_done && !phase_reg)
                    lroot_reg <= sq_root;
                else if (sq_done)
                    den_reg <= DB'(sq_root) * DB'(lroot_reg[RB-1:HB]) << HB;
            S_MUL:
                if (!phase_reg)
                    den_reg <= den_reg + DB'(sq_root) * DB'(den_lo_half);
                else
                    rem_reg <= QW'(mag);
            S_DIV:
            begin
                if (mag >= den_reg)
                    quo_reg <= 15'd16384;
                else if (q_bit)
                begin
                    rem_reg <= rem_sh - QW'(den_reg);
                    quo_reg <= {quo_reg[13:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[13:0], 1'b0};
                end
            end
            default:
                ;
        endcase
        if (state_reg == S_DIV && state_next == S_OUT)
        begin
            if (mag >= den_reg)
                dist_reg <= neg_reg ? 16'd32768 : 16'd0;
            else
                dist_reg <= dist_w[15:0];
        end
        if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
        begin
            within_reg <= !over && (dist_reg <= limit_reg);
            status_reg <= over ? ST_TOO_LONG : (zero ? ST_ZERO : ST_OK);
            pair_left  <= lrow_reg;
            pair_right <= rrow_reg;
            distance   <= dist_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign within_limit = within_reg;
    assign status       = status_reg;

    a_stall_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(distance)))
        else $error("stalled result changed");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CB'(MAX_DIM + 1))
        else $error("element count beyond saturation");
endmodule
`default_nettype wire
